// File: sv/dtmf_pkg.sv
package dtmf_pkg;

  // Sine table depth (a power of two) and the audio sample rate.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int RATE_HZ          = 8000;

  localparam int IDX_W         = $clog2(SINE_TABLE_DEPTH);
  localparam int QBITS         = IDX_W - 2;
  localparam int QUARTER_DEPTH = SINE_TABLE_DEPTH / 4;

  // Polynomial coefficients for sin(pi/2 * x), Q30.
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] C1      = 64'd1686629713;
  localparam logic [63:0] C3      = 64'd693598668;
  localparam logic [63:0] C5      = 64'd85569306;
  localparam logic [63:0] C7      = 64'd5026995;

  localparam logic [15:0] TONE_LENGTH_RESET = 16'd640;

  // Operation codes of an input item.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Key codes 0 to NUM_KEYS-1 are valid; KEY_UNKNOWN is ignored.
  localparam int         NUM_KEYS    = 15;
  localparam logic [3:0] KEY_UNKNOWN = 4'd15;

  typedef struct packed {
    logic       func;
    logic [3:0] key_code;
  } dtmf_in_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               tone_last;
  } dtmf_out_t;

  typedef logic [14:0] quarter_tab_t [QUARTER_DEPTH];
  typedef logic [31:0] step_tab_t [16];
  typedef int          hz_tab_t [16];

  localparam hz_tab_t KEY_LOW_HZ = '{
    941, 697, 697, 697, 770, 770, 770, 852, 852, 852, 941, 941, 0, 350, 480, 0
  };
  localparam hz_tab_t KEY_HIGH_HZ = '{
    1336, 1209, 1336, 1477, 1209, 1336, 1477, 1209, 1336, 1477, 1477, 1209, 0, 440, 620, 0
  };

  // Magnitude of 32767 * sin(pi/2 * x) for x in Q30, rounded half up.
  function automatic logic [14:0] sine_mag(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] s;
    logic [63:0] mag;
    x2  = (x * x) >> 30;
    y   = C7;
    y   = C5 - ((y * x2) >> 30);
    y   = C3 - ((y * x2) >> 30);
    y   = C1 - ((y * x2) >> 30);
    s   = (y * x) >> 30;
    mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t tab;
    for (int k = 0; k < QUARTER_DEPTH; k++) begin
      tab[k] = sine_mag((64'(k) << 30) / QUARTER_DEPTH);
    end
    return tab;
  endfunction

  function automatic step_tab_t build_step_tab(input hz_tab_t hz);
    step_tab_t tab;
    logic [63:0] num;
    for (int k = 0; k < 16; k++) begin
      num    = (64'(hz[k]) << 32) + 64'(RATE_HZ / 2);
      num    = num / RATE_HZ;
      tab[k] = num[31:0];
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER_TAB   = build_quarter_tab();
  localparam logic [14:0]  PEAK_MAG      = sine_mag(Q30_ONE);
  localparam step_tab_t    LOW_STEP_TAB  = build_step_tab(KEY_LOW_HZ);
  localparam step_tab_t    HIGH_STEP_TAB = build_step_tab(KEY_HIGH_HZ);

endpackage

// File: sv/dtmf_tone_generator_core.sv
// Dual-tone keypad generator. A load item (func 0) selects a key, resets both
// phase accumulators and arms a countdown of tone_length samples; it gives no
// result. A key code of 15 is ignored. Each tick item (func 1) gives one
// result: the truncated half sum of the two sine table values, with tone_last
// set on the final sample, or zero once the tone has ended. One item is
// accepted per clock while the output is not stalled. The table lookup, the
// sum and the phase adds are combinational; the result appears in the output
// register on the next cycle. tone_length takes effect at the next load.
module dtmf_tone_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtmf_pkg::dtmf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtmf_pkg::dtmf_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import dtmf_pkg::*;

  logic [15:0] tone_length_r;
  logic [31:0] low_phase_r, low_phase_nxt;
  logic [31:0] high_phase_r, high_phase_nxt;
  logic [31:0] low_step_r, low_step_nxt;
  logic [31:0] high_step_r, high_step_nxt;
  logic [15:0] samples_left_r, samples_left_nxt;
  logic        out_valid_r, out_valid_nxt;
  dtmf_out_t   out_data_r, out_data_nxt;

  logic               in_acc;
  logic               running;
  logic signed [15:0] low_sine, high_sine;
  logic signed [16:0] sum;
  logic signed [16:0] half;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign running  = (samples_left_r != '0);

  dtmf_sine_rom u_low_rom (
    .idx  (low_phase_r[31 -: IDX_W]),
    .sine (low_sine)
  );

  dtmf_sine_rom u_high_rom (
    .idx  (high_phase_r[31 -: IDX_W]),
    .sine (high_sine)
  );

  // Halve with truncation toward zero: bias odd negative sums up by one.
  assign sum  = 17'(low_sine) + 17'(high_sine);
  assign half = (sum + $signed(17'(sum[16] && sum[0]))) >>> 1;

  always_comb begin
    low_phase_nxt    = low_phase_r;
    high_phase_nxt   = high_phase_r;
    low_step_nxt     = low_step_r;
    high_step_nxt    = high_step_r;
    samples_left_nxt = samples_left_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    if (in_acc) begin
      if (in_data.func == FUNC_LOAD) begin
        if (in_data.key_code != KEY_UNKNOWN) begin
          low_step_nxt     = LOW_STEP_TAB[in_data.key_code];
          high_step_nxt    = HIGH_STEP_TAB[in_data.key_code];
          low_phase_nxt    = '0;
          high_phase_nxt   = '0;
          samples_left_nxt = tone_length_r;
        end
      end else begin
        out_valid_nxt = 1'b1;
        if (running) begin
          out_data_nxt.pcm_sample = half[15:0];
          out_data_nxt.tone_last  = (samples_left_r == 16'd1);
          low_phase_nxt           = low_phase_r + low_step_r;
          high_phase_nxt          = high_phase_r + high_step_r;
          samples_left_nxt        = samples_left_r - 16'd1;
        end else begin
          out_data_nxt.pcm_sample = '0;
          out_data_nxt.tone_last  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_length_r  <= TONE_LENGTH_RESET;
      low_phase_r    <= '0;
      high_phase_r   <= '0;
      low_step_r     <= '0;
      high_step_r    <= '0;
      samples_left_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tone_length_r <= cfg_wr_data;
      end
      low_phase_r    <= low_phase_nxt;
      high_phase_r   <= high_phase_nxt;
      low_step_r     <= low_step_nxt;
      high_step_r    <= high_step_nxt;
      samples_left_r <= samples_left_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A tick on the last remaining sample flags the end of the tone.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == FUNC_TICK && samples_left_r == 16'd1
    |=> out_valid_r && out_data_r.tone_last && samples_left_r == '0)
    else $error("final sample of a tone not flagged");

  // An idle tick gives a silent, unflagged item and leaves the phases alone.
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == FUNC_TICK && samples_left_r == '0
    |=> out_data_r.pcm_sample == '0 && !out_data_r.tone_last
        && $stable(low_phase_r) && $stable(high_phase_r))
    else $error("idle tick produced a nonzero item or moved a phase");

  // A load with the unknown key code leaves the tone state untouched.
  a_unknown_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == FUNC_LOAD && in_data.key_code == KEY_UNKNOWN
    |=> $stable(low_step_r) && $stable(high_step_r) && $stable(samples_left_r))
    else $error("unknown key changed the tone state");

  // A load never produces an item of its own.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == FUNC_LOAD && !(out_valid_r && out_stall)
    |=> !out_valid_r)
    else $error("load item produced an output item");

  // A result is flagged last only if the countdown has run out.
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == FUNC_TICK && samples_left_r > 16'd1
    |=> !out_data_r.tone_last)
    else $error("tone flagged last too early");

endmodule

// File: sv/dtmf_sine_rom.sv
module dtmf_sine_rom (
  input  logic [dtmf_pkg::IDX_W-1:0] idx,
  output logic signed [15:0]         sine
);
  import dtmf_pkg::*;

  logic [1:0]       quad;
  logic [QBITS-1:0] ofs;
  logic [14:0]      mag;

  assign quad = idx[IDX_W-1 -: 2];
  assign ofs  = idx[QBITS-1:0];

  // Quarter-wave table: odd quadrants read it mirrored; the mirror of
  // offset zero is the peak, which lies one past the table's end.
  always_comb begin
    if (!quad[0]) begin
      mag = QUARTER_TAB[ofs];
    end else if (ofs == '0) begin
      mag = PEAK_MAG;
    end else begin
      mag = QUARTER_TAB[QBITS'(QUARTER_DEPTH - int'(ofs))];
    end
  end

  assign sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: sim/tb_dtmf_tone_generator_core.sv
module tb_dtmf_tone_generator_core;
  import dtmf_pkg::*;

  localparam int CLK_HALF = 6;

  localparam logic [3:0] KEY_HASH    = 4'd10;
  localparam logic [3:0] KEY_STAR    = 4'd11;
  localparam logic [3:0] KEY_SILENCE = 4'd12;
  localparam logic [3:0] KEY_DIAL    = 4'd13;
  localparam logic [3:0] KEY_BUSY    = 4'd14;

  // Row and column frequencies of each key, in Hz.
  localparam int TONE_LO_HZ [NUM_KEYS] = '{
    941, 697, 697, 697, 770, 770, 770, 852, 852, 852, 941, 941, 0, 350, 480
  };
  localparam int TONE_HI_HZ [NUM_KEYS] = '{
    1336, 1209, 1336, 1477, 1209, 1336, 1477, 1209, 1336, 1477, 1477, 1209, 0, 440, 620
  };

  // Odd Taylor terms of sin(pi/2 * x) in Q30.
  localparam logic [63:0] SIN_K1 = 64'd1686629713;
  localparam logic [63:0] SIN_K3 = 64'd693598668;
  localparam logic [63:0] SIN_K5 = 64'd85569306;
  localparam logic [63:0] SIN_K7 = 64'd5026995;

  localparam int LEN_PLAN [8] = '{1, 65535, 0, 7, 640, 2, 23, 3};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  dtmf_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  dtmf_out_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  dtmf_tone_generator_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Expected generator state.
  int          sine_lut [SINE_TABLE_DEPTH];
  logic [15:0] gen_tone_length = 16'd640;
  logic [31:0] gen_low_phase = '0;
  logic [31:0] gen_high_phase = '0;
  logic [31:0] gen_low_step = '0;
  logic [31:0] gen_high_step = '0;
  logic [15:0] gen_samples_left = '0;

  dtmf_in_t  pending_items [$];
  dtmf_out_t expected_samples [$];
  int        items_queued = 0;
  int        errors = 0;

  function automatic int sine_value(input logic [31:0] p);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] s;
    logic [63:0] mag;
    x = {34'd0, p[29:0]};
    if (p[30]) begin
      x = (64'd1 << 30) - x;
    end
    x2  = (x * x) >> 30;
    y   = SIN_K7;
    y   = SIN_K5 - ((y * x2) >> 30);
    y   = SIN_K3 - ((y * x2) >> 30);
    y   = SIN_K1 - ((y * x2) >> 30);
    s   = (y * x) >> 30;
    mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return p[31] ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [31:0] phase_step(input int hz);
    logic [63:0] num;
    num = (64'(hz) << 32) + 64'(RATE_HZ / 2);
    num = num / 64'(RATE_HZ);
    return num[31:0];
  endfunction

  function automatic int lut_index(input logic [31:0] phase);
    logic [63:0] idx;
    idx = (64'(phase) * 64'(SINE_TABLE_DEPTH)) >> 32;
    if (idx >= 64'(SINE_TABLE_DEPTH)) begin
      idx = 64'(SINE_TABLE_DEPTH - 1);
    end
    return int'(idx);
  endfunction

  // Advances the generator by one accepted item and queues the sample that a tick gives.
  function automatic void predict_tone_item(input dtmf_in_t item);
    int        sum;
    dtmf_out_t sample;
    if (item.func == FUNC_LOAD) begin
      if (item.key_code < NUM_KEYS) begin
        gen_low_step     = phase_step(TONE_LO_HZ[item.key_code]);
        gen_high_step    = phase_step(TONE_HI_HZ[item.key_code]);
        gen_low_phase    = '0;
        gen_high_phase   = '0;
        gen_samples_left = gen_tone_length;
      end
    end else begin
      sample.pcm_sample = '0;
      sample.tone_last  = 1'b0;
      if (gen_samples_left != 0) begin
        sum = sine_lut[lut_index(gen_low_phase)] + sine_lut[lut_index(gen_high_phase)];
        sample.pcm_sample = 16'(sum / 2);
        gen_low_phase     = gen_low_phase + gen_low_step;
        gen_high_phase    = gen_high_phase + gen_high_step;
        gen_samples_left  = gen_samples_left - 16'd1;
        sample.tone_last  = (gen_samples_left == 0);
      end
      expected_samples.push_back(sample);
    end
  endfunction

  // Driver: each item waits a drawn number of idle cycles before it is offered.
  int   in_gap = 0;
  logic in_holding = 1'b0;
  logic in_pace = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_holding = 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_tone_item(in_data);
        in_holding = 1'b0;
        in_gap = in_pace ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 11) == 0) begin
          in_pace = !in_pace;
        end
      end
      if (!in_holding) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_holding = 1'b1;
        end
      end
      in_valid <= in_holding;
    end
  end

  // Monitor: checks each sample and stalls for a drawn number of cycles after it.
  // Twice it holds off long enough for the block to back up into its input.
  int   out_wait = 0;
  int   hold_left = 0;
  int   results_seen = 0;
  logic out_pace = 1'b1;
  dtmf_out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample: expected none, got pcm %0d last %0b",
                   $time, out_data.pcm_sample, out_data.tone_last);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data.pcm_sample !== want.pcm_sample) begin
            $display("%0t: pcm_sample mismatch: expected %0d, got %0d",
                     $time, want.pcm_sample, out_data.pcm_sample);
            errors++;
          end
          if (out_data.tone_last !== want.tone_last) begin
            $display("%0t: tone_last mismatch: expected %0b, got %0b",
                     $time, want.tone_last, out_data.tone_last);
            errors++;
          end
        end
        results_seen++;
        if (results_seen == 60 || results_seen == 220) begin
          hold_left = 60;
        end
        out_wait = out_pace ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 11) == 0) begin
          out_pace = !out_pace;
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (hold_left > 0) || (out_wait > 0);
    end
  end

  task automatic queue_item(input logic f, input logic [3:0] k);
    dtmf_in_t item;
    item.func     = f;
    item.key_code = k;
    pending_items.push_back(item);
    items_queued++;
  endtask

  // Loads give no sample, so the task waits on past the empty queues to let the last one settle.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_holding || expected_samples.size() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tone_length(input logic [15:0] len);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gen_tone_length = len;
  endtask

  initial begin
    int          plan_idx;
    int          new_len;
    int          tick_max;
    logic [3:0]  pick_key;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      sine_lut[i] = sine_value(32'((64'(i) << 32) / 64'(SINE_TABLE_DEPTH)));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset tone length: idle tick, ignored keys,
    // a running tone, and the silence key.
    queue_item(FUNC_TICK, 4'd0);
    queue_item(FUNC_LOAD, KEY_UNKNOWN);
    queue_item(FUNC_TICK, 4'd0);
    queue_item(FUNC_LOAD, 4'd5);
    repeat (3) queue_item(FUNC_TICK, 4'd0);
    queue_item(FUNC_LOAD, KEY_UNKNOWN);
    queue_item(FUNC_TICK, 4'd0);
    queue_item(FUNC_LOAD, KEY_SILENCE);
    repeat (2) queue_item(FUNC_TICK, 4'd0);
    wait_idle();
    write_tone_length(16'd1);
    queue_item(FUNC_LOAD, KEY_DIAL);
    repeat (2) queue_item(FUNC_TICK, 4'd0);
    wait_idle();
    // A zero length arms an empty tone.
    write_tone_length(16'd0);
    queue_item(FUNC_LOAD, KEY_BUSY);
    queue_item(FUNC_TICK, 4'd0);
    wait_idle();
    write_tone_length(16'd4);
    queue_item(FUNC_LOAD, 4'd0);
    repeat (2) queue_item(FUNC_TICK, 4'd0);
    wait_idle();
    // The running tone keeps its old count after this write.
    write_tone_length(16'hFFFF);
    repeat (3) queue_item(FUNC_TICK, 4'd0);
    queue_item(FUNC_LOAD, KEY_HASH);
    queue_item(FUNC_LOAD, KEY_STAR);
    queue_item(FUNC_TICK, 4'd0);

    // Random part: mostly a load followed by a run of ticks, with some noise.
    plan_idx = 0;
    while (items_queued < 425) begin
      wait_idle();
      new_len = (plan_idx < 8) ? LEN_PLAN[plan_idx] : $urandom_range(1, 30);
      plan_idx++;
      write_tone_length(16'(new_len));
      for (int s = 0; s < 5; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            queue_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
          end
        end else begin
          pick_key = ($urandom_range(0, 19) == 0) ? KEY_UNKNOWN :
                     4'($urandom_range(0, NUM_KEYS - 1));
          queue_item(FUNC_LOAD, pick_key);
          tick_max = (new_len + 2 < 40) ? new_len + 2 : 40;
          repeat ($urandom_range(0, tick_max)) queue_item(FUNC_TICK, 4'($urandom_range(0, 15)));
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * 300000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
